// ===== rtl/epx_pkg.sv =====
// Shared constants, types and helpers for the 26-direction extreme vertex block.
package epx_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int NDIR       = 26;
  localparam int COORD_W    = 24;
  localparam int SCORE_W    = 26;
  localparam int IDX_W      = 12;
  localparam int SLOT_W     = 5;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DRN_W      = $clog2(NDIR);

  // slot code of the zero direction, which has no result
  localparam logic [SLOT_W-1:0] SLOT_SKIP = SLOT_W'(13);

  // per-axis sign of a direction
  typedef enum logic [1:0] {
    AX_NEG  = 2'd0,
    AX_ZERO = 2'd1,
    AX_POS  = 2'd2
  } ax_t;

  typedef struct packed {
    ax_t dx;
    ax_t dy;
    ax_t dz;
  } dir_t;

  // per-cycle control broadcast to the cells and box units
  typedef struct packed {
    logic upd;    // point is taken into the set
    logic first;  // point opens a new set
    logic snap;   // set closes: copy results into the drain chain
    logic shift;  // drain chain advances by one result
  } epx_ctl_t;

  function automatic ax_t ax_of(input int unsigned code);
    ax_t a;
    a = AX_ZERO;
    if (code == 0) a = AX_NEG;
    if (code == 2) a = AX_POS;
    return a;
  endfunction

  // direction held by cell d, cells in ascending slot order
  function automatic dir_t dir_of(input int unsigned d);
    int unsigned s;
    dir_t r;
    s = (d < 13) ? d : d + 1;
    r.dx = ax_of(s / 9);
    r.dy = ax_of((s / 3) % 3);
    r.dz = ax_of(s % 3);
    return r;
  endfunction

endpackage

// ===== rtl/epx_box.sv =====
// One axis of the bounding box, with a copy taken when a set closes.
module epx_box
  import epx_pkg::*;
(
  input  logic                      clk,
  input  epx_ctl_t                  ctl,
  input  logic signed [COORD_W-1:0] v,
  output logic signed [COORD_W-1:0] min_q,
  output logic signed [COORD_W-1:0] max_q
);

  logic signed [COORD_W-1:0] min_r, min_nxt;
  logic signed [COORD_W-1:0] max_r, max_nxt;
  logic signed [COORD_W-1:0] smin_r, smin_nxt;
  logic signed [COORD_W-1:0] smax_r, smax_nxt;

  // running extremes; the first point of a set loads both
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.upd && (ctl.first || v < min_r)) min_nxt = v;
    if (ctl.upd && (ctl.first || v > max_r)) max_nxt = v;
    smin_nxt = ctl.snap ? min_nxt : smin_r;
    smax_nxt = ctl.snap ? max_nxt : smax_r;
  end

  always_ff @(posedge clk) begin
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    smin_r <= smin_nxt;
    smax_r <= smax_nxt;
  end

  assign min_q = smin_r;
  assign max_q = smax_r;

endmodule

// ===== rtl/epx_cell.sv =====
// One direction cell: best projection tracker plus one stage of the drain chain.
module epx_cell
  import epx_pkg::*;
(
  input  logic                      clk,
  input  epx_ctl_t                  ctl,
  input  dir_t                      dir,
  input  logic signed [COORD_W-1:0] px,
  input  logic signed [COORD_W-1:0] py,
  input  logic signed [COORD_W-1:0] pz,
  input  logic [IDX_W-1:0]          idx,
  input  logic [IDX_W-1:0]          chain_in,
  output logic [IDX_W-1:0]          chain_out
);

  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0]          bidx_r, bidx_nxt;
  logic [IDX_W-1:0]          drn_r, drn_nxt;
  logic signed [SCORE_W-1:0] score;

  function automatic logic signed [SCORE_W-1:0] term(input ax_t a,
                                                     input logic signed [COORD_W-1:0] v);
    logic signed [SCORE_W-1:0] ext;
    logic signed [SCORE_W-1:0] r;
    ext = SCORE_W'(v);
    unique case (a)
      AX_NEG:  r = -ext;
      AX_POS:  r = ext;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign score = term(dir.dx, px) + term(dir.dy, py) + term(dir.dz, pz);

  // strict greater-than keeps the earliest point on ties
  always_comb begin
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    if (ctl.upd && (ctl.first || score > best_r)) begin
      best_nxt = score;
      bidx_nxt = idx;
    end
  end

  // drain stage: load on set close, else pass toward the output
  always_comb begin
    drn_nxt = drn_r;
    if (ctl.snap) begin
      drn_nxt = bidx_nxt;
    end else if (ctl.shift) begin
      drn_nxt = chain_in;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    drn_r  <= drn_nxt;
  end

  assign chain_out = drn_r;

endmodule

// ===== rtl/extreme_vertex_26_directions.sv =====
// Top level of the 26-direction extreme vertex block.
// Takes one point per cycle and numbers the points of a set from 0. A row of 26
// cells, one per direction in ascending slot order, updates every direction's
// best projection in the same cycle. When the point marked last_point is taken,
// each cell copies its index into a drain register and the 26 results leave
// from the head of that chain, one per accepted output transaction, starting
// the cycle after that point. Points of the next set keep flowing during the
// drain; only its closing point waits (in_stall high) until the previous set's
// 26 results are gone, so closing points are at least 26 output transactions
// apart. Points beyond MAX_POINTS (4096) in a set are dropped and flag overflow.
module extreme_vertex_26_directions
  import epx_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_px,
  input  logic signed [COORD_W-1:0] in_py,
  input  logic signed [COORD_W-1:0] in_pz,
  input  logic                      in_last_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SLOT_W-1:0]         out_slot,
  output logic [IDX_W-1:0]          out_vertex_index,
  output logic signed [COORD_W-1:0] out_min_x,
  output logic signed [COORD_W-1:0] out_min_y,
  output logic signed [COORD_W-1:0] out_min_z,
  output logic signed [COORD_W-1:0] out_max_x,
  output logic signed [COORD_W-1:0] out_max_y,
  output logic signed [COORD_W-1:0] out_max_z,
  output logic                      out_overflow,
  output logic                      out_last_result
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             ovf_snap_r, ovf_snap_nxt;
  logic             busy_r, busy_nxt;
  logic [DRN_W-1:0] drain_r, drain_nxt;
  logic             in_acc, out_acc, full;
  epx_ctl_t         ctl;
  logic [IDX_W-1:0] chain [NDIR+1];

  // input side control
  assign in_stall = busy_r & in_last_point;
  assign in_acc   = in_valid & ~in_stall;
  assign full     = (count_r >= CNT_W'(MAX_POINTS));
  assign out_acc  = busy_r & ~out_stall;

  assign ctl.upd   = in_acc & ~full;
  assign ctl.first = (count_r == '0);
  assign ctl.snap  = in_acc & in_last_point;
  assign ctl.shift = out_acc;

  // set bookkeeping and drain sequencing
  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    ovf_snap_nxt = ovf_snap_r;
    busy_nxt     = busy_r;
    drain_nxt    = drain_r;
    if (ctl.upd) count_nxt = count_r + 1'b1;
    if (in_acc && full) ovf_nxt = 1'b1;
    if (out_acc) begin
      drain_nxt = drain_r + 1'b1;
      if (drain_r == DRN_W'(NDIR - 1)) busy_nxt = 1'b0;
    end
    if (ctl.snap) begin
      count_nxt    = '0;
      ovf_nxt      = 1'b0;
      ovf_snap_nxt = ovf_r | full;
      busy_nxt     = 1'b1;
      drain_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      busy_r  <= 1'b0;
      drain_r <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      busy_r  <= busy_nxt;
      drain_r <= drain_nxt;
    end
    ovf_snap_r <= ovf_snap_nxt;
  end

  // row of direction cells; the drain chain flows toward cell 0
  assign chain[NDIR] = '0;

  for (genvar i = 0; i < NDIR; i++) begin : g_cell
    epx_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .dir       (dir_of(i)),
      .px        (in_px),
      .py        (in_py),
      .pz        (in_pz),
      .idx       (IDX_W'(count_r)),
      .chain_in  (chain[i+1]),
      .chain_out (chain[i])
    );
  end

  // bounding box, one unit per axis
  epx_box u_box_x (.clk(clk), .ctl(ctl), .v(in_px), .min_q(out_min_x), .max_q(out_max_x));
  epx_box u_box_y (.clk(clk), .ctl(ctl), .v(in_py), .min_q(out_min_y), .max_q(out_max_y));
  epx_box u_box_z (.clk(clk), .ctl(ctl), .v(in_pz), .min_q(out_min_z), .max_q(out_max_z));

  // result fields
  assign out_valid        = busy_r;
  assign out_vertex_index = chain[0];
  assign out_slot         = (SLOT_W'(drain_r) >= SLOT_SKIP) ? SLOT_W'(drain_r) + 1'b1
                                                            : SLOT_W'(drain_r);
  assign out_overflow     = ovf_snap_r;
  assign out_last_result  = (drain_r == DRN_W'(NDIR - 1));

`ifndef ASSERT_OFF
  // drain counter stays within the 26 results
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (drain_r <= DRN_W'(NDIR - 1)))
    else $error("drain counter out of range");

  // a closing point starts a fresh drain at the first result
  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_point) |=> (out_valid && drain_r == '0))
    else $error("set close did not start drain");

  // the last result ends the drain
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> !out_valid)
    else $error("drain continued past last result");

  // point count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");
`endif

endmodule

// ===== sim/tb_extreme_vertex_26_directions.sv =====
// Testbench for extreme_vertex_26_directions: random point sets, per-result scoreboard check.
`timescale 1ns / 1ps

// one result transaction as seen on the output channel
typedef struct packed {
  logic [epx_pkg::SLOT_W-1:0]  slot;
  logic [epx_pkg::IDX_W-1:0]   vidx;
  logic [epx_pkg::COORD_W-1:0] min_x, min_y, min_z;
  logic [epx_pkg::COORD_W-1:0] max_x, max_y, max_z;
  logic                        ovf;
  logic                        last;
} dop_result_t;

// Tracks extremes of the open point set and holds the results still owed by the block.
class dop_extreme_tracker;
  int          best_proj[epx_pkg::NDIR];
  int unsigned best_idx[epx_pkg::NDIR];
  int          box_lo[3];
  int          box_hi[3];
  int unsigned count;
  bit          ovf_seen;
  dop_result_t owed[$];
  int          mismatches;

  function new();
    count      = 0;
    ovf_seen   = 1'b0;
    mismatches = 0;
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // fold one accepted point into the set; a closing point queues all 26 results
  function void take_point(input logic [epx_pkg::COORD_W-1:0] x, y, z, input logic last);
    int          p[3];
    int          s;
    int          sl;
    bit          first;
    dop_result_t r;
    p[0] = $signed(x);
    p[1] = $signed(y);
    p[2] = $signed(z);
    if (count >= epx_pkg::MAX_POINTS) begin
      ovf_seen = 1'b1;
    end else begin
      first = (count == 0);
      for (int a = 0; a < 3; a++) begin
        if (first || p[a] < box_lo[a]) box_lo[a] = p[a];
        if (first || p[a] > box_hi[a]) box_hi[a] = p[a];
      end
      for (int d = 0; d < epx_pkg::NDIR; d++) begin
        sl = (d < 13) ? d : d + 1;
        s  = (sl / 9 - 1) * p[0] + ((sl / 3) % 3 - 1) * p[1] + (sl % 3 - 1) * p[2];
        // strict compare: ties keep the earlier point
        if (first || s > best_proj[d]) begin
          best_proj[d] = s;
          best_idx[d]  = count;
        end
      end
      count++;
    end
    if (last) begin
      for (int d = 0; d < epx_pkg::NDIR; d++) begin
        sl      = (d < 13) ? d : d + 1;
        r.slot  = sl[epx_pkg::SLOT_W-1:0];
        r.vidx  = best_idx[d][epx_pkg::IDX_W-1:0];
        r.min_x = box_lo[0][epx_pkg::COORD_W-1:0];
        r.min_y = box_lo[1][epx_pkg::COORD_W-1:0];
        r.min_z = box_lo[2][epx_pkg::COORD_W-1:0];
        r.max_x = box_hi[0][epx_pkg::COORD_W-1:0];
        r.max_y = box_hi[1][epx_pkg::COORD_W-1:0];
        r.max_z = box_hi[2][epx_pkg::COORD_W-1:0];
        r.ovf   = ovf_seen;
        r.last  = (d == epx_pkg::NDIR - 1);
        owed = {owed, r};
      end
      count    = 0;
      ovf_seen = 1'b0;
    end
  endfunction

  function string show(dop_result_t r);
    return $sformatf("slot %0d idx %0d min (%0d,%0d,%0d) max (%0d,%0d,%0d) ovf %0b last %0b",
                     r.slot, r.vidx, $signed(r.min_x), $signed(r.min_y), $signed(r.min_z),
                     $signed(r.max_x), $signed(r.max_y), $signed(r.max_z), r.ovf, r.last);
  endfunction

  // compare one output transaction against the oldest owed result
  function void check_result(dop_result_t got);
    dop_result_t want;
    string       diffs;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with none owed: %s", show(got));
      return;
    end
    want  = owed.pop_front();
    diffs = "";
    if (got.slot  !== want.slot)  diffs = {diffs, " slot"};
    if (got.vidx  !== want.vidx)  diffs = {diffs, " vertex_index"};
    if (got.min_x !== want.min_x) diffs = {diffs, " min_x"};
    if (got.min_y !== want.min_y) diffs = {diffs, " min_y"};
    if (got.min_z !== want.min_z) diffs = {diffs, " min_z"};
    if (got.max_x !== want.max_x) diffs = {diffs, " max_x"};
    if (got.max_y !== want.max_y) diffs = {diffs, " max_y"};
    if (got.max_z !== want.max_z) diffs = {diffs, " max_z"};
    if (got.ovf   !== want.ovf)   diffs = {diffs, " overflow"};
    if (got.last  !== want.last)  diffs = {diffs, " last_result"};
    if (diffs != "") begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in%s", diffs);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction
endclass

module tb_extreme_vertex_26_directions;
  import epx_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_px;
  logic signed [COORD_W-1:0] in_py;
  logic signed [COORD_W-1:0] in_pz;
  logic                      in_last_point;
  logic                      out_valid;
  logic                      out_stall;
  logic [SLOT_W-1:0]         out_slot;
  logic [IDX_W-1:0]          out_vertex_index;
  logic signed [COORD_W-1:0] out_min_x;
  logic signed [COORD_W-1:0] out_min_y;
  logic signed [COORD_W-1:0] out_min_z;
  logic signed [COORD_W-1:0] out_max_x;
  logic signed [COORD_W-1:0] out_max_y;
  logic signed [COORD_W-1:0] out_max_z;
  logic                      out_overflow;
  logic                      out_last_result;

  dop_extreme_tracker tracker;
  bit                 calm;
  int                 hold_off_requests = 0;
  int                 points_sent = 0;

  extreme_vertex_26_directions DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_px            (in_px),
    .in_py            (in_py),
    .in_pz            (in_pz),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot         (out_slot),
    .out_vertex_index (out_vertex_index),
    .out_min_x        (out_min_x),
    .out_min_y        (out_min_y),
    .out_min_z        (out_min_z),
    .out_max_x        (out_max_x),
    .out_max_y        (out_max_y),
    .out_max_z        (out_max_z),
    .out_overflow     (out_overflow),
    .out_last_result  (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long; none at all in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small values force equal projections, extremes hit the range limits
  function automatic logic [COORD_W-1:0] rand_coord();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      t = $urandom_range(0, 8);
      t = t - 4;
      return t[COORD_W-1:0];
    end
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0: return 24'h7FFFFF;
        1: return 24'h800000;
        2: return 24'h000000;
        3: return 24'hFFFFFF;
        default: return 24'h000001;
      endcase
    end
    return COORD_W'($urandom());
  endfunction

  // one input transaction, held until accepted, then an optional gap
  task automatic send_point(input logic [COORD_W-1:0] x, y, z, input logic last);
    int g;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_px         <= x;
    in_py         <= y;
    in_pz         <= z;
    in_last_point <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_point(x, y, z, last);
    points_sent++;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int served;
    int g;
    stall_left = 0;
    served     = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (served != hold_off_requests) begin
        served     = hold_off_requests;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        g = pick_gap();
        out_stall <= (g > 0);
        if (g > 0) stall_left = g - 1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(dop_result_t'{out_slot, out_vertex_index,
                                         out_min_x, out_min_y, out_min_z,
                                         out_max_x, out_max_y, out_max_z,
                                         out_overflow, out_last_result});
  end

  // stimulus
  initial begin
    int n;
    int r;
    int start;
    tracker       = new();
    calm          = 1'b1;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_px         = '0;
    in_py         = '0;
    in_pz         = '0;
    in_last_point = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    calm = 1'b0;

    // single-point sets at the range limits and with alternating bits
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b1);
    send_point(24'h555555, 24'hAAAAAA, 24'h000000, 1'b1);

    // mixed extremes: projections reach three times full scale
    send_point(24'h7FFFFF, 24'h800000, 24'h000000, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h000000, 24'h000000, 24'h800000, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1);

    // identical points: the first one wins every direction
    send_point(24'h000100, 24'hFFFF00, 24'h000100, 1'b0);
    send_point(24'h000100, 24'hFFFF00, 24'h000100, 1'b0);
    send_point(24'h000100, 24'hFFFF00, 24'h000100, 1'b1);

    // later points tie earlier ones along several directions
    send_point(24'h000001, 24'h000000, 24'h000000, 1'b0);
    send_point(24'h000000, 24'h000001, 24'h000000, 1'b0);
    send_point(24'h000000, 24'h000000, 24'h000001, 1'b0);
    send_point(24'h000001, 24'h000001, 24'h000000, 1'b0);
    send_point(24'hFFFFFF, 24'h000000, 24'h000001, 1'b1);

    // set past capacity; the dropped points are extreme and the close is dropped too
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i == MAX_POINTS - 1) send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
      else send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
    end
    send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 24'h800000, 1'b0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b1);
    // the next set must start with overflow cleared
    send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);

    // long receiver hold-off while small sets keep coming, then a full drain
    wait_drained();
    hold_off_requests++;
    calm = 1'b1;
    repeat (12) send_set(3);
    calm = 1'b0;
    wait_drained();

    // random sets, mostly small
    start = points_sent;
    while (points_sent < start + 450) begin
      calm = ($urandom_range(0, 7) == 0);
      r    = $urandom_range(0, 99);
      if (r < 80) n = $urandom_range(1, 8);
      else if (r < 95) n = $urandom_range(9, 30);
      else n = $urandom_range(31, 80);
      send_set(n);
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("tb_extreme_vertex_26_directions: clean");
    end else begin
      $display("tb_extreme_vertex_26_directions: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #250_000_000;
    $display("tb_extreme_vertex_26_directions: errors");
    $finish;
  end

endmodule
